/* rtl/dpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_pkg
// Shared types and constants of the position engine.
// ----------------------------------------------------------------------------
package dpe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned KIND_W = 5;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CODE_W = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_START_PAGE = 2'd0;
  localparam logic [1:0] CFG_END_PAGE   = 2'd1;
  localparam logic [1:0] CFG_PARITY     = 2'd2;

  // page selection codes
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_ODD  = 2'd2;

  // result event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CHAR  = 2'd1;
  localparam logic [1:0] EV_RECT  = 2'd2;
  localparam logic [1:0] EV_FLUSH = 2'd3;

  typedef enum logic [4:0] {
    OP_BOP     = 5'd0,
    OP_EOP     = 5'd1,
    OP_SETCHAR = 5'd2,
    OP_PUTCHAR = 5'd3,
    OP_SETRULE = 5'd4,
    OP_PUTRULE = 5'd5,
    OP_RIGHT   = 5'd6,
    OP_DOWN    = 5'd7,
    OP_W0      = 5'd8,
    OP_W       = 5'd9,
    OP_X0      = 5'd10,
    OP_X       = 5'd11,
    OP_Y0      = 5'd12,
    OP_Y       = 5'd13,
    OP_Z0      = 5'd14,
    OP_Z       = 5'd15,
    OP_PUSH    = 5'd16,
    OP_POP     = 5'd17,
    OP_DIR     = 5'd18,
    OP_NOP     = 5'd19
  } op_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] rule_height;
    logic [CODE_W-1:0]        char_code;
    logic signed [WORD_W-1:0] char_advance;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               event_res;
    logic signed [WORD_W-1:0] pos_h;
    logic signed [WORD_W-1:0] pos_v;
    logic signed [WORD_W-1:0] rect_width;
    logic signed [WORD_W-1:0] rect_height;
    logic [CODE_W-1:0]        glyph;
    logic                     printing;
    logic                     stack_error;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e                      op;
    logic [WORD_W-1:0]        value;
    logic [WORD_W-1:0]        rule_height;
    logic [CODE_W-1:0]        char_code;
    logic [WORD_W-1:0]        char_advance;
  } cmd_t;

  // one saved stack frame
  typedef struct packed {
    logic [WORD_W-1:0] h;
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic              dir;
  } frame_t;

  typedef struct packed {
    logic              we;
    logic [1:0]        idx;
    logic [WORD_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic stack_op;
    logic stack_err;
    logic sp_over;
  } back_status_t;

endpackage

/* rtl/dpe_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/dpe_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_queue
// Two-entry register queue that decouples producer and consumer.
// ----------------------------------------------------------------------------
module dpe_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/dpe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_front
// Accepts input transactions, classifies the command kind and queues it.
// ----------------------------------------------------------------------------
module dpe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dpe_pkg::in_item_t in_item_i,
  output logic              full_o,
  input  logic              cmd_pop_i,
  output logic              cmd_valid_o,
  output dpe_pkg::cmd_t     cmd_o
);

  localparam logic [dpe_pkg::KIND_W-1:0] KindMax = dpe_pkg::OP_DIR;

  dpe_pkg::cmd_t cmd_in;
  logic          q_empty;

  // classify the kind, unknown codes become no-ops
  always_comb begin
    cmd_in.op           = (in_item_i.kind > KindMax) ? dpe_pkg::OP_NOP
                                                     : dpe_pkg::op_e'(in_item_i.kind);
    cmd_in.value        = in_item_i.value;
    cmd_in.rule_height  = in_item_i.rule_height;
    cmd_in.char_code    = in_item_i.char_code;
    cmd_in.char_advance = in_item_i.char_advance;
  end

  dpe_queue #(
    .WIDTH ($bits(dpe_pkg::cmd_t))
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .empty_o (q_empty),
    .rdata_o (cmd_o)
  );

  assign cmd_valid_o = !q_empty;

endmodule

/* rtl/dpe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_back
// Executes one command per cycle unless stalled: position registers, stack and page mode.
// ----------------------------------------------------------------------------
module dpe_back #(
  parameter int unsigned STACK_DEPTH = dpe_pkg::STACK_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dpe_pkg::cfg_t           cfg_i,
  input  logic                    cmd_valid_i,
  input  dpe_pkg::cmd_t           cmd_i,
  output logic                    cmd_pop_o,
  input  logic                    res_full_i,
  output logic                    res_push_o,
  output dpe_pkg::out_item_t      res_o,
  output dpe_pkg::back_status_t   status_o
);

  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SpMax = SPW'(STACK_DEPTH);

  // configuration registers
  logic signed [dpe_pkg::WORD_W-1:0] start_q, end_q;
  logic [1:0]                        parity_q;

  // position state
  logic [dpe_pkg::WORD_W-1:0] h_q, h_d, v_q, v_d, w_q, w_d, x_q, x_d;
  logic [dpe_pkg::WORD_W-1:0] y_q, y_d, z_q, z_d;
  logic                       dir_q, dir_d, print_q, print_d;
  logic [SPW-1:0]             sp_q, sp_d;
  dpe_pkg::frame_t            top_q, top_d, below, byp_data_q, ram_rdata;
  logic                       byp_q;

  logic                       fire, ram_we, bop_ok, par_ok, err;
  logic                       adv_en, down_en;
  logic [dpe_pkg::WORD_W-1:0] adv_amt, down_amt;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [SPW:0]               raddr_full;
  logic [SPW-1:0]             sp_m1;
  dpe_pkg::frame_t            cur_frame;
  dpe_pkg::out_item_t         res;

  assign fire       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;
  assign sp_m1      = sp_q - SPW'(1);

  assign cur_frame = '{h: h_q, v: v_q, w: w_q, x: x_q, y: y_q, z: z_q, dir: dir_q};
  assign below     = byp_q ? byp_data_q : ram_rdata;

  // page selection check
  always_comb begin
    case (parity_q)
      dpe_pkg::PAR_EVEN: par_ok = !cmd_i.value[0];
      dpe_pkg::PAR_ODD:  par_ok = cmd_i.value[0] && !cmd_i.value[dpe_pkg::WORD_W-1];
      default:           par_ok = 1'b1;
    endcase
    bop_ok = ($signed(cmd_i.value) <= end_q) && par_ok &&
             (print_q || ($signed(cmd_i.value) >= start_q));
  end

  // command execution
  always_comb begin
    h_d = h_q; v_d = v_q; w_d = w_q; x_d = x_q; y_d = y_q; z_d = z_q;
    dir_d = dir_q; print_d = print_q; sp_d = sp_q; top_d = top_q;
    adv_en = 1'b0; adv_amt = cmd_i.value;
    down_en = 1'b0; down_amt = cmd_i.value;
    err = 1'b0; ram_we = 1'b0;
    res = '0;
    if (fire) begin
      if (cmd_i.op == dpe_pkg::OP_BOP) begin
        if (bop_ok) begin
          print_d = 1'b1;
          h_d = '0; v_d = '0; w_d = '0; x_d = '0; y_d = '0; z_d = '0;
          sp_d = '0;
        end else begin
          print_d = 1'b0;
        end
      end else if (print_q) begin
        case (cmd_i.op)
          dpe_pkg::OP_EOP: res.event_res = dpe_pkg::EV_FLUSH;
          dpe_pkg::OP_SETCHAR, dpe_pkg::OP_PUTCHAR: begin
            res.event_res = dpe_pkg::EV_CHAR;
            res.pos_h = h_q;
            res.pos_v = v_q;
            res.glyph = cmd_i.char_code;
            adv_en  = (cmd_i.op == dpe_pkg::OP_SETCHAR);
            adv_amt = cmd_i.char_advance;
          end
          dpe_pkg::OP_SETRULE, dpe_pkg::OP_PUTRULE: begin
            res.event_res = dpe_pkg::EV_RECT;
            res.pos_h = h_q;
            res.pos_v = v_q;
            if (!dir_q) begin
              res.rect_width  = cmd_i.value;
              res.rect_height = cmd_i.rule_height;
            end else begin
              res.rect_width  = cmd_i.rule_height;
              res.rect_height = -cmd_i.value;
            end
            adv_en = (cmd_i.op == dpe_pkg::OP_SETRULE);
          end
          dpe_pkg::OP_RIGHT: adv_en = 1'b1;
          dpe_pkg::OP_DOWN:  down_en = 1'b1;
          dpe_pkg::OP_W0: begin adv_en = 1'b1; adv_amt = w_q; end
          dpe_pkg::OP_W:  begin adv_en = 1'b1; w_d = cmd_i.value; end
          dpe_pkg::OP_X0: begin adv_en = 1'b1; adv_amt = x_q; end
          dpe_pkg::OP_X:  begin adv_en = 1'b1; x_d = cmd_i.value; end
          dpe_pkg::OP_Y0: begin down_en = 1'b1; down_amt = y_q; end
          dpe_pkg::OP_Y:  begin down_en = 1'b1; y_d = cmd_i.value; end
          dpe_pkg::OP_Z0: begin down_en = 1'b1; down_amt = z_q; end
          dpe_pkg::OP_Z:  begin down_en = 1'b1; z_d = cmd_i.value; end
          dpe_pkg::OP_PUSH: begin
            if (sp_q >= SpMax) begin
              err = 1'b1;
            end else begin
              // old top spills into the ram, current state becomes top
              ram_we = (sp_q != '0);
              top_d  = cur_frame;
              sp_d   = sp_q + SPW'(1);
            end
          end
          dpe_pkg::OP_POP: begin
            if (sp_q == '0) begin
              err = 1'b1;
            end else begin
              h_d = top_q.h; v_d = top_q.v; w_d = top_q.w; x_d = top_q.x;
              y_d = top_q.y; z_d = top_q.z; dir_d = top_q.dir;
              top_d = below;
              sp_d  = sp_m1;
            end
          end
          dpe_pkg::OP_DIR: dir_d = (cmd_i.value != '0);
          default: ;
        endcase
      end
      // advance and downward move relative to the writing direction
      if (adv_en) begin
        if (!dir_q) h_d = h_q + adv_amt;
        else        v_d = v_q + adv_amt;
      end
      if (down_en) begin
        if (!dir_q) v_d = v_q + down_amt;
        else        h_d = h_q - down_amt;
      end
      res.printing    = print_d;
      res.stack_error = err;
    end
  end

  assign res_o = res;

  // ram keeps frames below the top, read address tracks the next one down
  assign ram_waddr  = sp_m1[AW-1:0];
  assign raddr_full = {1'b0, sp_d} - (SPW+1)'(2);
  assign ram_raddr  = raddr_full[AW-1:0];

  dpe_ram #(
    .WIDTH ($bits(dpe_pkg::frame_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (top_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q <= {1'b0, {(dpe_pkg::WORD_W-1){1'b1}}};
      parity_q <= '0;
      h_q <= '0; v_q <= '0; w_q <= '0; x_q <= '0; y_q <= '0; z_q <= '0;
      dir_q <= 1'b0;
      print_q <= 1'b1;
      sp_q <= '0;
      byp_q <= 1'b0;
    end else begin
      h_q <= h_d; v_q <= v_d; w_q <= w_d; x_q <= x_d; y_q <= y_d; z_q <= z_d;
      dir_q <= dir_d;
      sp_q <= sp_d;
      byp_q <= ram_we;
      // a start page write reloads the print mode as at reset
      if (cfg_i.we && (cfg_i.idx == dpe_pkg::CFG_START_PAGE)) begin
        print_q <= ($signed(cfg_i.data) <= 0);
      end else begin
        print_q <= print_d;
      end
      if (cfg_i.we) begin
        case (cfg_i.idx)
          dpe_pkg::CFG_START_PAGE: start_q <= cfg_i.data;
          dpe_pkg::CFG_END_PAGE:   end_q <= cfg_i.data;
          dpe_pkg::CFG_PARITY:     parity_q <= cfg_i.data[1:0];
          default: ;
        endcase
      end
    end
  end

  // stack top and write bypass data
  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    byp_data_q <= top_q;
  end

  assign status_o = '{fire:      fire,
                      stack_op:  (cmd_i.op == dpe_pkg::OP_PUSH) ||
                                 (cmd_i.op == dpe_pkg::OP_POP),
                      stack_err: err,
                      sp_over:   (sp_q > SpMax)};

endmodule

/* rtl/dvi_position_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvi_position_engine
// Executes decoded page commands and reports draw, flush and stack events.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through a queue-style port: a transaction is taken when
//   push is high and full is low. Results leave through a queue-style port:
//   the oldest result is on out_item_o while empty is low and is taken when
//   pop is high. Every command yields exactly one result.
//   The front classifies commands into a two-entry command queue; the back
//   executes one command per cycle and writes a two-entry result queue.
//   Each command is registered in the command queue and its result in the
//   result queue, from which it is popped.
//   Throughput is one command per cycle while the result queue has room,
//   set by the executor and its stack ram, whose top frame is held in
//   registers and next frame is prefetched every cycle.
//   If the receiver stalls, the result queue and then the command queue fill,
//   after which full rises; nothing is dropped. Reset empties both queues,
//   clears positions and the stack, and restores default page settings.
//   Configuration writes through cfg_we_i, cfg_idx_i and cfg_wdata_i take
//   effect at once; issuing them only while idle is up to the user.
// ----------------------------------------------------------------------------
module dvi_position_engine #(
  parameter int unsigned STACK_DEPTH = dpe_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  dpe_pkg::in_item_t           in_item_i,
  output logic                        full,
  output logic                        empty,
  input  logic                        pop,
  output dpe_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [dpe_pkg::WORD_W-1:0]  cfg_wdata_i
);

  logic                  cmd_valid, cmd_pop, res_full, res_push;
  dpe_pkg::cmd_t         cmd;
  dpe_pkg::out_item_t    res;
  dpe_pkg::cfg_t         cfg;
  dpe_pkg::back_status_t status;

  assign cfg = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_wdata_i};

  dpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  dpe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .status_o    (status)
  );

  // result queue
  dpe_queue #(
    .WIDTH ($bits(dpe_pkg::out_item_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_item_o)
  );

  // stack pointer never passes the stack depth
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) !status.sp_over)
    else $error("stack pointer beyond depth");

  // a stack error only comes from push or pop
  a_err_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fire && status.stack_err |-> status.stack_op)
    else $error("stack error on non-stack command");

  // execution only with a queued command and room for the result
  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fire |-> cmd_valid && !res_full)
    else $error("executed without command or result room");

  // an executed command shows up as a result in the next cycle
  a_res_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fire |=> !empty)
    else $error("result lost");

endmodule
